// ===== hdl/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types, token kind codes and character class functions for the
// source text tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

   localparam int PosBits = 16;
   localparam int LenBits = 8;
   localparam int KwCount = 34;

   localparam logic [PosBits-1:0] POS_MAX = {PosBits{1'b1}};
   localparam logic [LenBits-1:0] LEN_MAX = {LenBits{1'b1}};

   localparam logic [6:0] K_EOL    = 7'd0;
   localparam logic [6:0] K_STRING = 7'd1;
   localparam logic [6:0] K_KEY0   = 7'd2;
   localparam logic [6:0] K_REAL   = 7'd36;
   localparam logic [6:0] K_INT    = 7'd37;
   localparam logic [6:0] K_IDENT  = 7'd38;
   localparam logic [6:0] K_LPAR   = 7'd39;
   localparam logic [6:0] K_RPAR   = 7'd40;
   localparam logic [6:0] K_LBRK   = 7'd41;
   localparam logic [6:0] K_RBRK   = 7'd42;
   localparam logic [6:0] K_LTSTAR = 7'd43;
   localparam logic [6:0] K_STARGT = 7'd44;
   localparam logic [6:0] K_PLUS   = 7'd45;
   localparam logic [6:0] K_MINUS  = 7'd46;
   localparam logic [6:0] K_POW    = 7'd47;
   localparam logic [6:0] K_STAR   = 7'd48;
   localparam logic [6:0] K_NE     = 7'd49;
   localparam logic [6:0] K_DSLASH = 7'd50;
   localparam logic [6:0] K_SLPCT  = 7'd51;
   localparam logic [6:0] K_SLASH  = 7'd52;
   localparam logic [6:0] K_ASSIGN = 7'd53;
   localparam logic [6:0] K_COLON  = 7'd54;
   localparam logic [6:0] K_HASH   = 7'd55;
   localparam logic [6:0] K_COMMA  = 7'd56;
   localparam logic [6:0] K_SEMI   = 7'd57;
   localparam logic [6:0] K_ARROW  = 7'd58;
   localparam logic [6:0] K_GE     = 7'd59;
   localparam logic [6:0] K_LE     = 7'd60;
   localparam logic [6:0] K_GT     = 7'd61;
   localparam logic [6:0] K_LT     = 7'd62;
   localparam logic [6:0] K_EQ     = 7'd63;
   localparam logic [6:0] K_ERROR  = 7'd64;
   localparam logic [6:0] K_NONE   = 7'd127;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_WORD = 4'd1;
   localparam logic [3:0] S_INT  = 4'd2;
   localparam logic [3:0] S_DOT  = 4'd3;
   localparam logic [3:0] S_FRAC = 4'd4;
   localparam logic [3:0] S_EXPE = 4'd5;
   localparam logic [3:0] S_EXPS = 4'd6;
   localparam logic [3:0] S_EXPD = 4'd7;
   localparam logic [3:0] S_STR  = 4'd8;
   localparam logic [3:0] S_SYM  = 4'd9;

   localparam logic [47:0] KW_TABLE [KwCount] = '{
      48'h616e64, 48'h63616c6c, 48'h63617365, 48'h646f, 48'h656c7365,
      48'h656e64, 48'h65736163, 48'h65786974, 48'h6578_7465_726e,
      48'h6669, 48'h666f72, 48'h66726f6d, 48'h66756e, 48'h6966,
      48'h696e707574, 48'h696e_7465_726e, 48'h6e6c66, 48'h6e6f74,
      48'h6f64, 48'h6f72, 48'h6f75_7470_7574, 48'h70726f63,
      48'h7265_7065_6174, 48'h7265_7475_726e, 48'h73746570,
      48'h74657874, 48'h7468656e, 48'h746f, 48'h756e74696c,
      48'h7768656e, 48'h7768696c65, 48'h796573, 48'h6e6f,
      48'h656d707479
   };

   typedef struct packed {
      logic [6:0]         kind;
      logic [PosBits-1:0] line;
      logic [PosBits-1:0] col;
      logic [LenBits-1:0] len;
      logic               last;
   } result_type;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_delim(input logic [7:0] c);
      return c == 8'h20 || c == 8'h09 || c == 8'h0a || c == 8'h2e || c == 8'h2c ||
             c == 8'h3a || c == 8'h3b || c == 8'h28 || c == 8'h29 || c == 8'h5b ||
             c == 8'h5d || c == 8'h3c || c == 8'h3e || c == 8'h2b || c == 8'h2d ||
             c == 8'h2a || c == 8'h2f || c == 8'h25 || c == 8'h23 || c == 8'h3d ||
             c == 8'h22;
   endfunction

   function automatic logic [6:0] single_kind(input logic [7:0] c);
      logic [6:0] k;
      k = K_NONE;
      unique case (c)
         8'h28: k = K_LPAR;
         8'h29: k = K_RPAR;
         8'h5b: k = K_LBRK;
         8'h5d: k = K_RBRK;
         8'h2b: k = K_PLUS;
         8'h2d: k = K_MINUS;
         8'h2a: k = K_STAR;
         8'h2f: k = K_SLASH;
         8'h3a: k = K_COLON;
         8'h23: k = K_HASH;
         8'h2c: k = K_COMMA;
         8'h3b: k = K_SEMI;
         8'h3e: k = K_GT;
         8'h3c: k = K_LT;
         8'h3d: k = K_EQ;
         default: k = K_NONE;
      endcase
      return k;
   endfunction

   function automatic logic may_pair(input logic [7:0] c);
      return c == 8'h3c || c == 8'h2a || c == 8'h2f || c == 8'h3a ||
             c == 8'h3d || c == 8'h3e;
   endfunction

   function automatic logic [6:0] pair_kind(input logic [7:0] h, input logic [7:0] e);
      logic [6:0] k;
      k = K_NONE;
      priority if (h == 8'h3c && e == 8'h2a) k = K_LTSTAR;
      else if (h == 8'h2a && e == 8'h3e) k = K_STARGT;
      else if (h == 8'h2a && e == 8'h2a) k = K_POW;
      else if (h == 8'h2f && e == 8'h3d) k = K_NE;
      else if (h == 8'h2f && e == 8'h2f) k = K_DSLASH;
      else if (h == 8'h2f && e == 8'h25) k = K_SLPCT;
      else if (h == 8'h3a && e == 8'h3d) k = K_ASSIGN;
      else if (h == 8'h3d && e == 8'h3e) k = K_ARROW;
      else if (h == 8'h3e && e == 8'h3d) k = K_GE;
      else if (h == 8'h3c && e == 8'h3d) k = K_LE;
      else k = K_NONE;
      return k;
   endfunction

   function automatic logic [6:0] kw_lookup(input logic [47:0] w);
      logic [6:0] k;
      k = K_IDENT;
      for (int i = 0; i < KwCount; i++) begin
         if (KW_TABLE[i] == w) k = K_KEY0 + 7'(i);
      end
      return k;
   endfunction

endpackage

// ===== hdl/stt_scan.sv =====
// ----------------------------------------------------------------------------
// stt_scan
// Scanner state registers and the per-character next-state logic; produces
// up to two tokens for each accepted character.
// ----------------------------------------------------------------------------
module stt_scan (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   take,
   input  logic [7:0]             char_code,
   input  logic                   end_of_input,
   output logic [1:0]             res_count,
   output stt_pkg::result_type    res0,
   output stt_pkg::result_type    res1
);
   import stt_pkg::*;

   logic [3:0]         state_ff, state_in;
   logic [6:0]         cand_ff, cand_in;
   logic [47:0]        word_ff, word_in;
   logic [PosBits-1:0] sline_ff, sline_in, scol_ff, scol_in;
   logic [PosBits-1:0] cline_ff, cline_in, ccol_ff, ccol_in;
   logic [LenBits-1:0] plen_ff, plen_in;
   logic               cmt_ff, cmt_in;
   logic [7:0]         held_ff, held_in;
   logic               halt_ff, halt_in;

   result_type         r [2];
   logic [1:0]         n;

   always_comb begin
      logic [7:0]  e;
      logic        used;
      logic        keep;
      logic [6:0]  k;
      logic [LenBits-1:0] plen_inc;
      state_in = state_ff;  cand_in = cand_ff;  word_in = word_ff;
      sline_in = sline_ff;  scol_in = scol_ff;  cline_in = cline_ff;
      ccol_in  = ccol_ff;   plen_in = plen_ff;  cmt_in  = cmt_ff;
      held_in  = held_ff;   halt_in = halt_ff;
      r[0] = '0;
      r[1] = '0;
      n = 2'd0;
      e = 8'h20;
      used = 1'b0;
      keep = 1'b0;
      k = K_NONE;
      plen_inc = (plen_ff == LEN_MAX) ? plen_ff : plen_ff + 1'b1;

      if (take && !halt_ff) begin
         if (end_of_input) begin
            unique case (state_ff)
               S_WORD: begin
                  r[n[0]] = '{(plen_ff <= LenBits'(6)) ? kw_lookup(word_ff) : K_IDENT,
                              sline_ff, scol_ff, plen_ff, 1'b0};
                  n = n + 1'b1;
               end
               S_INT: begin
                  r[n[0]] = '{K_INT, sline_ff, scol_ff, plen_ff, 1'b0};
                  n = n + 1'b1;
               end
               S_DOT, S_EXPE, S_EXPS: begin
                  r[0] = '{K_INT, sline_ff, scol_ff, word_ff[32 +: LenBits], 1'b0};
                  r[1] = '{K_ERROR, sline_ff, word_ff[PosBits-1:0], '0, 1'b0};
                  n = 2'd2;
                  halt_in = 1'b1;
               end
               S_FRAC, S_EXPD: begin
                  r[n[0]] = '{K_REAL, sline_ff, scol_ff, plen_ff, 1'b0};
                  n = n + 1'b1;
               end
               S_STR: begin
                  r[n[0]] = '{K_ERROR, sline_ff, scol_ff, '0, 1'b0};
                  n = n + 1'b1;
                  halt_in = 1'b1;
               end
               S_SYM: begin
                  r[n[0]] = '{cand_ff, sline_ff, scol_ff, LenBits'(1), 1'b0};
                  n = n + 1'b1;
               end
               default: ;
            endcase
            // start a new text; halt survives
            keep = halt_in;
            state_in = S_IDLE;  cand_in = K_NONE;  word_in = '0;
            sline_in = PosBits'(1);  scol_in = '0;
            cline_in = PosBits'(1);  ccol_in = '0;
            plen_in = '0;  cmt_in = 1'b0;  held_in = '0;
            halt_in = keep;
         end else begin
            cmt_in = (char_code == 8'h0a) ? 1'b0 : (cmt_ff || char_code == 8'h5c);
            e = cmt_in ? 8'h20 : char_code;

            unique case (state_ff)
               S_WORD: begin
                  if (is_letter(e) || is_digit(e) || e == 8'h5f) begin
                     word_in = {word_ff[39:0], is_letter(e) ? (e | 8'h20) : e};
                     plen_in = plen_inc;
                     used = 1'b1;
                  end else begin
                     r[n[0]] = '{(is_delim(e) && plen_ff <= LenBits'(6)) ?
                                 kw_lookup(word_ff) : K_IDENT,
                                 sline_ff, scol_ff, plen_ff, 1'b0};
                     n = n + 1'b1;
                     state_in = S_IDLE;
                  end
               end
               S_INT: begin
                  if (is_digit(e)) begin
                     plen_in = plen_inc;
                     used = 1'b1;
                  end else if (e == 8'h2e) begin
                     word_in = {8'h00, LenBits'(plen_ff), 16'(0) , 16'(0)};
                     word_in[32 +: LenBits] = plen_ff;
                     word_in[PosBits-1:0] = ccol_ff;
                     plen_in = plen_inc;
                     state_in = S_DOT;
                     used = 1'b1;
                  end else begin
                     r[n[0]] = '{K_INT, sline_ff, scol_ff, plen_ff, 1'b0};
                     n = n + 1'b1;
                     state_in = S_IDLE;
                  end
               end
               S_DOT, S_EXPS, S_EXPE: begin
                  used = 1'b1;
                  if (is_digit(e)) begin
                     plen_in = plen_inc;
                     state_in = (state_ff == S_DOT) ? S_FRAC : S_EXPD;
                  end else if (state_ff == S_EXPE && (e == 8'h2b || e == 8'h2d)) begin
                     plen_in = plen_inc;
                     state_in = S_EXPS;
                  end else begin
                     r[0] = '{K_INT, sline_ff, scol_ff, word_ff[32 +: LenBits], 1'b0};
                     r[1] = '{K_ERROR, sline_ff, word_ff[PosBits-1:0], '0, 1'b0};
                     n = 2'd2;
                     halt_in = 1'b1;
                     state_in = S_IDLE;
                  end
               end
               S_FRAC, S_EXPD: begin
                  if (is_digit(e)) begin
                     plen_in = plen_inc;
                     used = 1'b1;
                  end else if (state_ff == S_FRAC && (e == 8'h65 || e == 8'h45)) begin
                     plen_in = plen_inc;
                     state_in = S_EXPE;
                     used = 1'b1;
                  end else begin
                     r[n[0]] = '{K_REAL, sline_ff, scol_ff, plen_ff, 1'b0};
                     n = n + 1'b1;
                     state_in = S_IDLE;
                  end
               end
               S_STR: begin
                  used = 1'b1;
                  plen_in = plen_inc;
                  if (e == 8'h22) begin
                     r[n[0]] = '{K_STRING, sline_ff, scol_ff, plen_inc, 1'b0};
                     n = n + 1'b1;
                     state_in = S_IDLE;
                  end else if (e == 8'h0a) begin
                     r[n[0]] = '{K_ERROR, sline_ff, scol_ff, '0, 1'b0};
                     n = n + 1'b1;
                     halt_in = 1'b1;
                     state_in = S_IDLE;
                  end
               end
               S_SYM: begin
                  k = pair_kind(held_ff, e);
                  state_in = S_IDLE;
                  if (k != K_NONE) begin
                     r[n[0]] = '{k, sline_ff, scol_ff, LenBits'(2), 1'b0};
                     used = 1'b1;
                  end else begin
                     r[n[0]] = '{cand_ff, sline_ff, scol_ff, LenBits'(1), 1'b0};
                  end
                  n = n + 1'b1;
               end
               default: state_in = S_IDLE;
            endcase

            // character not consumed by the pending token opens a new one
            if (!used && !halt_in) begin
               sline_in = cline_ff;
               scol_in  = ccol_ff;
               plen_in  = LenBits'(1);
               priority if (e == 8'h20 || e == 8'h09) begin
               end else if (e == 8'h0a) begin
                  r[n[0]] = '{K_EOL, cline_ff, ccol_ff, LenBits'(1), 1'b0};
                  n = n + 1'b1;
               end else if (e == 8'h22) begin
                  state_in = S_STR;
               end else if (is_letter(e)) begin
                  word_in = {40'd0, e | 8'h20};
                  state_in = S_WORD;
               end else if (is_digit(e)) begin
                  state_in = S_INT;
               end else if (may_pair(e)) begin
                  held_in = e;
                  cand_in = single_kind(e);
                  state_in = S_SYM;
               end else if (single_kind(e) != K_NONE) begin
                  r[n[0]] = '{single_kind(e), cline_ff, ccol_ff, LenBits'(1), 1'b0};
                  n = n + 1'b1;
               end else begin
                  r[n[0]] = '{K_ERROR, cline_ff, ccol_ff, '0, 1'b0};
                  n = n + 1'b1;
                  halt_in = 1'b1;
                  state_in = S_IDLE;
               end
            end

            if (char_code == 8'h0a) begin
               if (cline_ff != POS_MAX) cline_in = cline_ff + 1'b1;
               ccol_in = '0;
            end else if (ccol_ff != POS_MAX) begin
               ccol_in = ccol_ff + 1'b1;
            end
         end
      end

      if (n == 2'd1) r[0].last = 1'b1;
      if (n == 2'd2) r[1].last = 1'b1;
   end

   assign res_count = n;
   assign res0 = r[0];
   assign res1 = r[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cand_ff  <= K_NONE;
         word_ff  <= '0;
         sline_ff <= PosBits'(1);
         scol_ff  <= '0;
         cline_ff <= PosBits'(1);
         ccol_ff  <= '0;
         plen_ff  <= '0;
         cmt_ff   <= 1'b0;
         held_ff  <= '0;
         halt_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cand_ff  <= cand_in;
         word_ff  <= word_in;
         sline_ff <= sline_in;
         scol_ff  <= scol_in;
         cline_ff <= cline_in;
         ccol_ff  <= ccol_in;
         plen_ff  <= plen_in;
         cmt_ff   <= cmt_in;
         held_ff  <= held_in;
         halt_ff  <= halt_in;
      end
   end

endmodule

// ===== hdl/stt_queue.sv =====
// ----------------------------------------------------------------------------
// stt_queue
// Four-entry token queue: takes up to two tokens per cycle, hands out one.
// ----------------------------------------------------------------------------
module stt_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic [1:0]          push_count,
   input  stt_pkg::result_type push0,
   input  stt_pkg::result_type push1,
   input  logic                pop,
   output stt_pkg::result_type head,
   output logic                not_empty,
   output logic                almost_full
);
   import stt_pkg::*;

   result_type  mem_ff [4];
   logic [1:0]  wp_ff, wp_in, rp_ff, rp_in;
   logic [2:0]  cnt_ff, cnt_in;

   assign wp_in  = wp_ff + push_count;
   assign rp_in  = rp_ff + {1'b0, pop};
   assign cnt_in = cnt_ff + {1'b0, push_count} - {2'b00, pop};

   assign head        = mem_ff[rp_ff];
   assign not_empty   = cnt_ff != 3'd0;
   assign almost_full = cnt_ff > 3'd2;

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) mem_ff[wp_ff] <= push0;
      if (push_count == 2'd2) mem_ff[wp_ff + 2'd1] <= push1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== hdl/source_text_tokenizer_unit.sv =====
// ----------------------------------------------------------------------------
// source_text_tokenizer_unit
// Streaming lexer: one source byte per transaction in, tokens out.
// ----------------------------------------------------------------------------
// Input channel req_: one byte (req_char_code) or an end-of-text mark
// (req_end_of_input) per transaction. Output channel rsp_: one token per
// transaction with kind, line, start column, length; rsp_last_of_run marks
// the last token caused by one input transaction (an input causes 0 to 2).
// The scanner updates its state in the cycle a byte is accepted and writes
// the tokens into a four-entry queue; every token is registered there and
// is shown on rsp_ at its head. One byte is accepted each cycle while the
// queue holds at most two tokens, so throughput is one byte per cycle as
// long as tokens drain; the queue depth sets how much stall is absorbed.
// When rsp_stall is high, tokens wait in the queue and req_stall rises once
// it holds three or more. Synchronous reset returns to line 1 column 0,
// clears the queue and leaves the halted state entered after an error.
// ----------------------------------------------------------------------------
module source_text_tokenizer_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [7:0]                  req_char_code,
   input  logic                        req_end_of_input,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [6:0]                  rsp_token_kind,
   output logic [stt_pkg::PosBits-1:0] rsp_line_number,
   output logic [stt_pkg::PosBits-1:0] rsp_column_number,
   output logic [stt_pkg::LenBits-1:0] rsp_token_length,
   output logic                        rsp_last_of_run
);
   import stt_pkg::*;

   logic       take;
   logic [1:0] res_count;
   result_type res0, res1, head;
   logic       not_empty, almost_full;

   assign req_stall = almost_full;
   assign take      = req_valid && !almost_full;

   stt_scan u_scan (
      .clock        (clock),
      .reset        (reset),
      .take         (take),
      .char_code    (req_char_code),
      .end_of_input (req_end_of_input),
      .res_count    (res_count),
      .res0         (res0),
      .res1         (res1)
   );

   stt_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_count  (res_count),
      .push0       (res0),
      .push1       (res1),
      .pop         (not_empty && !rsp_stall),
      .head        (head),
      .not_empty   (not_empty),
      .almost_full (almost_full)
   );

   assign rsp_valid         = not_empty;
   assign rsp_token_kind    = head.kind;
   assign rsp_line_number   = head.line;
   assign rsp_column_number = head.col;
   assign rsp_token_length  = head.len;
   assign rsp_last_of_run   = head.last;

endmodule
